FILE: hw/rtl/gf65536_lane_multiply_accumulate_assert.svh
// Assertion helpers for the GF(2^16) multiply-accumulate block.
// Both expect clk and arst_n in scope.
`ifndef GF65536_LANE_MULTIPLY_ACCUMULATE_ASSERT_SVH
`define GF65536_LANE_MULTIPLY_ACCUMULATE_ASSERT_SVH

// Same-cycle implication
`define GFLMAC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define GFLMAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gflmac_pkg.sv
`timescale 1ns / 1ps

package gflmac_pkg;

	localparam int FIELD_BITS    = 16;
	localparam int PROD_BITS     = 2 * FIELD_BITS - 1;
	// one reduction term per product bit above the field
	localparam int RED_TERMS     = PROD_BITS - FIELD_BITS;
	localparam int HALF_BITS     = FIELD_BITS / 2;
	localparam int MAX_LANES     = 8;
	localparam int LANE_COUNT_DEFAULT = 8;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_ADDR_BITS = 5;
	localparam int REG_ADDR_LSB  = 3;
	localparam int REG_IDX_BITS  = CFG_ADDR_BITS - REG_ADDR_LSB;

	localparam logic [FIELD_BITS-1:0] POLY_RESET = 16'h100B;

	// register indexes
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_POLY    = 2'd0,
		REG_MULT_LO = 2'd1,
		REG_MULT_HI = 2'd2
	} reg_idx_t;

	// entry j holds x^(FIELD_BITS+j) mod poly
	typedef logic [RED_TERMS-1:0][FIELD_BITS-1:0] red_table_t;

	// Build the reduction table: the first half by repeated doubling,
	// the rest by a multiply by x^8 that reuses the first half.
	function automatic red_table_t gf_red_table(input logic [FIELD_BITS-1:0] poly);
		red_table_t             t;
		logic [FIELD_BITS-1:0]  r;
		logic [FIELD_BITS-1:0]  v;
		t = '0;
		r = poly;
		t[0] = poly;
		for (int j = 1; j < HALF_BITS; j++) begin
			r = {r[FIELD_BITS-2:0], 1'b0} ^ (r[FIELD_BITS-1] ? poly : '0);
			t[j] = r;
		end
		for (int j = HALF_BITS; j < RED_TERMS; j++) begin
			v = {t[j-HALF_BITS][HALF_BITS-1:0], {HALF_BITS{1'b0}}};
			for (int i = 0; i < HALF_BITS; i++) begin
				if (t[j-HALF_BITS][HALF_BITS+i])
					v = v ^ t[i];
			end
			t[j] = v;
		end
		return t;
	endfunction

endpackage

FILE: hw/rtl/gflmac_lane.sv
`timescale 1ns / 1ps

// One lane: acc XOR (multiplier * coefficient) in GF(2^16).
module gflmac_lane (
	input  logic [gflmac_pkg::FIELD_BITS-1:0] multiplier,
	input  logic [gflmac_pkg::FIELD_BITS-1:0] coefficient,
	input  logic [gflmac_pkg::FIELD_BITS-1:0] acc,
	input  gflmac_pkg::red_table_t            red_table,
	output logic [gflmac_pkg::FIELD_BITS-1:0] result
);
	import gflmac_pkg::*;

	logic [PROD_BITS-1:0]  prod;
	logic [FIELD_BITS-1:0] reduced;

	// carry-less product, partial products are independent
	always_comb begin
		prod = '0;
		for (int i = 0; i < FIELD_BITS; i++) begin
			if (coefficient[i])
				prod = prod ^ ({{(PROD_BITS-FIELD_BITS){1'b0}}, multiplier} << i);
		end
	end

	// fold high product bits back in through the reduction table
	always_comb begin
		reduced = prod[FIELD_BITS-1:0];
		for (int j = 0; j < RED_TERMS; j++) begin
			if (prod[FIELD_BITS+j])
				reduced = reduced ^ red_table[j];
		end
	end

	assign result = acc ^ reduced;

endmodule

FILE: hw/rtl/gf65536_lane_multiply_accumulate.sv
`timescale 1ns / 1ps

// Lane-parallel GF(2^16) multiply-accumulate. Each beat on the input channel carries
// a coefficient and one accumulator word per lane; the result beat carries, per lane,
// acc XOR (multiplier * coefficient) reduced by reduction_poly (x^16 implied), and
// last passes through. One beat is taken every cycle while in_stall is low; a beat
// passes the input register, then the whole field multiply, then the result register.
// While a result is held by out_stall an empty input register still takes one more
// beat; after that in_stall follows out_stall until the held result leaves. Registers
// on the APB port (64-bit data): reduction_poly at 0x00, lane 0-3 multipliers at
// 0x08, lane 4-7 multipliers at 0x10. A polynomial write also refreshes the internal
// reduction table at the same edge. Lanes at or above LANE_COUNT read as zero.
`include "gf65536_lane_multiply_accumulate_assert.svh"

module gf65536_lane_multiply_accumulate #(
	parameter int LANE_COUNT = gflmac_pkg::LANE_COUNT_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gflmac_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [gflmac_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [gflmac_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                                 pready,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    coefficient,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    acc_in_0,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    acc_in_1,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    acc_in_2,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    acc_in_3,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    acc_in_4,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    acc_in_5,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    acc_in_6,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]    acc_in_7,
	input  logic                                 last_in,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [gflmac_pkg::FIELD_BITS-1:0]    acc_out_0,
	output logic [gflmac_pkg::FIELD_BITS-1:0]    acc_out_1,
	output logic [gflmac_pkg::FIELD_BITS-1:0]    acc_out_2,
	output logic [gflmac_pkg::FIELD_BITS-1:0]    acc_out_3,
	output logic [gflmac_pkg::FIELD_BITS-1:0]    acc_out_4,
	output logic [gflmac_pkg::FIELD_BITS-1:0]    acc_out_5,
	output logic [gflmac_pkg::FIELD_BITS-1:0]    acc_out_6,
	output logic [gflmac_pkg::FIELD_BITS-1:0]    acc_out_7,
	output logic                                 last_out
);
	import gflmac_pkg::*;

	// configuration registers
	logic [FIELD_BITS-1:0]    poly_q;
	red_table_t               red_q;
	logic [CFG_DATA_BITS-1:0] mult_lo_q;
	logic [CFG_DATA_BITS-1:0] mult_hi_q;
	logic                     cfg_write;
	reg_idx_t                 cfg_idx;

	// pipeline
	logic                                   valid_s1;
	logic [FIELD_BITS-1:0]                  coef_s1;
	logic [LANE_COUNT-1:0][FIELD_BITS-1:0]  acc_s1;
	logic                                   last_s1;
	logic                                   valid_s2;
	logic [LANE_COUNT-1:0][FIELD_BITS-1:0]  acc_s2;
	logic                                   last_s2;
	logic                                   ready_s1;
	logic                                   ready_s2;
	logic                                   adv_s2;

	logic [MAX_LANES-1:0][FIELD_BITS-1:0]   acc_in_all;
	logic [MAX_LANES-1:0][FIELD_BITS-1:0]   acc_out_all;
	logic [MAX_LANES*FIELD_BITS-1:0]        mult_all;
	logic [LANE_COUNT-1:0][FIELD_BITS-1:0]  lane_res;

	// APB decode
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[CFG_ADDR_BITS-1:REG_ADDR_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q    <= POLY_RESET;
			red_q     <= gf_red_table(POLY_RESET);
			mult_lo_q <= '0;
			mult_hi_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_POLY: begin
					poly_q <= pwdata[FIELD_BITS-1:0];
					red_q  <= gf_red_table(pwdata[FIELD_BITS-1:0]);
				end
				REG_MULT_LO: begin
					mult_lo_q <= pwdata;
				end
				REG_MULT_HI: begin
					mult_hi_q <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	// read-back
	always_comb begin
		unique case (cfg_idx)
			REG_POLY:    prdata = {{(CFG_DATA_BITS-FIELD_BITS){1'b0}}, poly_q};
			REG_MULT_LO: prdata = mult_lo_q;
			REG_MULT_HI: prdata = mult_hi_q;
			default:     prdata = '0;
		endcase
	end

	assign mult_all   = {mult_hi_q, mult_lo_q};
	assign acc_in_all = {acc_in_7, acc_in_6, acc_in_5, acc_in_4,
	                     acc_in_3, acc_in_2, acc_in_1, acc_in_0};

	// flow control: two-deep pipeline, a held result stalls stage one once it is full
	assign ready_s2 = !valid_s2 || !out_stall;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign adv_s2   = valid_s1 && ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			coef_s1 <= coefficient;
			acc_s1  <= acc_in_all[LANE_COUNT-1:0];
			last_s1 <= last_in;
		end
		if (adv_s2) begin
			acc_s2  <= lane_res;
			last_s2 <= last_s1;
		end
	end

	// field multiply per lane
	for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
		gflmac_lane u_lane (
			.multiplier  (mult_all[g*FIELD_BITS +: FIELD_BITS]),
			.coefficient (coef_s1),
			.acc         (acc_s1[g]),
			.red_table   (red_q),
			.result      (lane_res[g])
		);
	end

	// unused lanes read as zero
	for (genvar g = 0; g < MAX_LANES; g++) begin : g_out
		if (g < LANE_COUNT) begin : g_used
			assign acc_out_all[g] = acc_s2[g];
		end else begin : g_unused
			assign acc_out_all[g] = '0;
		end
	end

	assign out_valid = valid_s2;
	assign last_out  = last_s2;
	assign acc_out_0 = acc_out_all[0];
	assign acc_out_1 = acc_out_all[1];
	assign acc_out_2 = acc_out_all[2];
	assign acc_out_3 = acc_out_all[3];
	assign acc_out_4 = acc_out_all[4];
	assign acc_out_5 = acc_out_all[5];
	assign acc_out_6 = acc_out_all[6];
	assign acc_out_7 = acc_out_all[7];

	// checks
	`GFLMAC_ASSERT_NOW(a_red_base, 1'b1, red_q[0] == poly_q, "reduction table out of step with poly")
	`GFLMAC_ASSERT_NEXT(a_s1_moves, adv_s2, valid_s2, "stage one beat lost on its way out")
	`GFLMAC_ASSERT_NEXT(a_zero_coef, adv_s2 && coef_s1 == '0, acc_s2[0] == $past(acc_s1[0]), "zero coefficient changed the accumulator")

endmodule

FILE: tb/gflmac_result_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the GF(2^16) lane MAC,
// keeps its own copy of the registers, predicts every result beat and compares.
module gflmac_result_checker #(
	parameter int LANE_COUNT = gflmac_pkg::LANE_COUNT_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// configuration port
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic                                     pready,
	input  logic [gflmac_pkg::CFG_ADDR_BITS-1:0]     paddr,
	input  logic [gflmac_pkg::CFG_DATA_BITS-1:0]     pwdata,
	// input channel
	input  logic                                     in_valid,
	input  logic                                     in_stall,
	input  logic [gflmac_pkg::FIELD_BITS-1:0]        coefficient,
	input  logic [gflmac_pkg::MAX_LANES-1:0][gflmac_pkg::FIELD_BITS-1:0] acc_in,
	input  logic                                     last_in,
	// result channel
	input  logic                                     out_valid,
	input  logic                                     out_stall,
	input  logic [gflmac_pkg::MAX_LANES-1:0][gflmac_pkg::FIELD_BITS-1:0] acc_out,
	input  logic                                     last_out,
	// status to the top
	output int                                       errors,
	output int                                       pending
);
	import gflmac_pkg::*;

	typedef struct packed {
		logic [MAX_LANES-1:0][FIELD_BITS-1:0] lanes;
		logic                                 last;
	} mac_beat_t;

	localparam int MAX_REPORTS = 10;

	logic [FIELD_BITS-1:0] poly_q;
	logic [63:0]           mult_lo_q;
	logic [63:0]           mult_hi_q;

	mac_beat_t expected_beats [$];
	int        fail_count = 0;
	int        beat_count = 0;

	// Field product, most significant coefficient bit first, shift-and-XOR reduction
	function automatic logic [FIELD_BITS-1:0] gf_product(input logic [FIELD_BITS-1:0] a,
			input logic [FIELD_BITS-1:0] b, input logic [FIELD_BITS-1:0] poly);
		logic [FIELD_BITS-1:0] p;
		p = '0;
		for (int i = FIELD_BITS - 1; i >= 0; i--) begin
			p = {p[FIELD_BITS-2:0], 1'b0} ^ (p[FIELD_BITS-1] ? poly : '0);
			if (b[i])
				p = p ^ a;
		end
		return p;
	endfunction

	// Expected result beat for one input beat under the current registers
	function automatic mac_beat_t predict_mac(input logic [FIELD_BITS-1:0] coef,
			input logic [MAX_LANES-1:0][FIELD_BITS-1:0] acc, input logic last);
		mac_beat_t             r;
		logic [FIELD_BITS-1:0] m;
		r = '0;
		for (int k = 0; k < MAX_LANES; k++) begin
			m = (k < 4) ? mult_lo_q[16*k +: 16] : mult_hi_q[16*(k-4) +: 16];
			if (k < LANE_COUNT)
				r.lanes[k] = acc[k] ^ gf_product(m, coef, poly_q);
		end
		r.last = last;
		return r;
	endfunction

	// Register copy, written on the access edge of an APB write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q    <= POLY_RESET;
			mult_lo_q <= '0;
			mult_hi_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[CFG_ADDR_BITS-1:REG_ADDR_LSB]))
				REG_POLY:    poly_q    <= pwdata[FIELD_BITS-1:0];
				REG_MULT_LO: mult_lo_q <= pwdata[63:0];
				REG_MULT_HI: mult_hi_q <= pwdata[63:0];
				default: ;
			endcase
		end
	end

	// Predict on every accepted input beat, compare every accepted result beat
	always @(posedge clk) begin
		mac_beat_t want;
		mac_beat_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_beats.push_back(predict_mac(coefficient, acc_in, last_in));
			if (out_valid && !out_stall) begin
				got.lanes = acc_out;
				got.last  = last_out;
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result beat %0d: lanes %h last %b",
							beat_count, got.lanes, got.last);
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("beat %0d mismatch: expected %h last %b, got %h last %b",
								beat_count, want.lanes, want.last, got.lanes, got.last);
					end
				end
				beat_count++;
			end
		end
		pending <= expected_beats.size();
		errors  <= fail_count;
	end

endmodule

FILE: tb/tb_gf65536_lane_multiply_accumulate.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the GF(2^16) lane MAC; checking lives in the checker.
module tb_gf65536_lane_multiply_accumulate;
	import gflmac_pkg::*;

	localparam int LANES       = LANE_COUNT_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEGMENTS    = 8;
	localparam int SEG_BEATS   = 144;
	// index past the register list, writes there must be dropped
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;
	localparam logic [15:0] DIR_COEF [7] = '{16'h0000, 16'h0001, 16'h0002, 16'h8000,
		16'hFFFF, 16'h00FF, 16'hFF00};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                     psel    = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite  = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr   = '0;
	logic [CFG_DATA_BITS-1:0] pwdata  = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	logic                                 in_valid    = 1'b0;
	logic                                 in_stall;
	logic [FIELD_BITS-1:0]                coefficient = '0;
	logic [MAX_LANES-1:0][FIELD_BITS-1:0] acc_in      = '0;
	logic                                 last_in     = 1'b0;

	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [MAX_LANES-1:0][FIELD_BITS-1:0] acc_out;
	logic                                 last_out;

	int errors;
	int pending;
	int cycle_count = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	gf65536_lane_multiply_accumulate #(
		.LANE_COUNT(LANES)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .coefficient(coefficient),
		.acc_in_0(acc_in[0]), .acc_in_1(acc_in[1]), .acc_in_2(acc_in[2]),
		.acc_in_3(acc_in[3]), .acc_in_4(acc_in[4]), .acc_in_5(acc_in[5]),
		.acc_in_6(acc_in[6]), .acc_in_7(acc_in[7]), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.acc_out_0(acc_out[0]), .acc_out_1(acc_out[1]), .acc_out_2(acc_out[2]),
		.acc_out_3(acc_out[3]), .acc_out_4(acc_out[4]), .acc_out_5(acc_out[5]),
		.acc_out_6(acc_out[6]), .acc_out_7(acc_out[7]), .last_out(last_out)
	);

	gflmac_result_checker #(
		.LANE_COUNT(LANES)
	) i_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .coefficient(coefficient),
		.acc_in(acc_in), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall), .acc_out(acc_out),
		.last_out(last_out),
		.errors(errors), .pending(pending)
	);

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Field word biased towards the edges
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001 << $urandom_range(0, 15);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [63:0] pick_mults();
		logic [63:0] v;
		for (int k = 0; k < 4; k++)
			v[16*k +: 16] = pick_word();
		return v;
	endfunction

	function automatic logic [15:0] pick_poly();
		case ($urandom_range(0, 5))
			0: return POLY_RESET;
			1: return 16'h0000;
			2: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// APB write: setup cycle, then access cycle until pready
	task automatic cfg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [63:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_BITS'(idx) << REG_ADDR_LSB;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [15:0] coef,
			input logic [MAX_LANES-1:0][FIELD_BITS-1:0] acc, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		coefficient <= coef;
		acc_in      <= acc;
		last_in     <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [MAX_LANES-1:0][FIELD_BITS-1:0] pick_acc();
		logic [MAX_LANES-1:0][FIELD_BITS-1:0] a;
		for (int k = 0; k < MAX_LANES; k++)
			a[k] = pick_word();
		return a;
	endfunction

	initial begin
		logic [MAX_LANES-1:0][FIELD_BITS-1:0] acc;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: multipliers are zero, so results equal the accumulators
		send_beat(16'hFFFF, {MAX_LANES{16'hFFFF}}, 1'b1);
		send_beat(16'h0000, '0, 1'b0);
		drain();

		// edge multipliers against edge coefficients, default polynomial
		cfg_write(REG_MULT_LO, 64'hFFFF_8000_0002_0001);
		cfg_write(REG_MULT_HI, 64'h0000_1234_00FF_FF00);
		for (int i = 0; i < 7; i++) begin
			case (i % 4)
				0: acc = '0;
				1: acc = {MAX_LANES{16'hFFFF}};
				2: acc = {(MAX_LANES/2){16'hAAAA, 16'h5555}};
				default: acc = pick_acc();
			endcase
			send_beat(DIR_COEF[i], acc, i[0]);
		end
		drain();

		// zero polynomial, reduction drops the high part
		cfg_write(REG_POLY, 64'h0);
		send_beat(16'h8000, '0, 1'b1);
		send_beat(16'hFFFF, {MAX_LANES{16'hFFFF}}, 1'b0);
		drain();

		// all-ones polynomial, not primitive
		cfg_write(REG_POLY, 64'hFFFF);
		send_beat(16'h8000, '0, 1'b0);
		send_beat(16'hFFFF, '0, 1'b1);
		send_beat(16'h1234, pick_acc(), 1'b0);
		drain();

		// write past the register list must change nothing
		cfg_write(REG_SPARE, '1);
		send_beat(16'hFFFF, '0, 1'b1);
		send_beat(pick_word(), pick_acc(), 1'b0);
		drain();

		// random segments, each with fresh registers and one of four idling and stall patterns
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 86; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 86; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			cfg_write(REG_POLY, 64'(pick_poly()));
			cfg_write(REG_MULT_LO, (seg == 3) ? '1 : pick_mults());
			cfg_write(REG_MULT_HI, (seg == 5) ? '1 : pick_mults());
			for (int n = 0; n < SEG_BEATS; n++)
				send_beat(pick_word(), pick_acc(), ($urandom_range(0, 7) == 0));
			drain();
		end

		idle_pct  = 0;
		stall_pct = 0;
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
